// ===== rtl/wlcm_pkg.sv =====
// Shared types, register indexes and opcodes for the window/level color mapper.
// No dependencies; every other file in rtl uses it by scoped names.
`default_nettype none
package wlcm_pkg;

	localparam int COLOR_ENTRIES_DEF = 256;
	localparam int MAP_ENTRIES_DEF   = 65536;

	localparam logic [1:0] OP_MAP       = 2'd0;
	localparam logic [1:0] OP_WR_DIRECT = 2'd1;
	localparam logic [1:0] OP_WR_COLOR  = 2'd2;
	localparam logic [1:0] OP_UNUSED    = 2'd3;

	localparam logic [2:0] REG_WINDOW      = 3'd0;
	localparam logic [2:0] REG_LEVEL       = 3'd1;
	localparam logic [2:0] REG_THR_LOWER   = 3'd2;
	localparam logic [2:0] REG_THR_UPPER   = 3'd3;
	localparam logic [2:0] REG_THR_ENABLE  = 3'd4;
	localparam logic [2:0] REG_DIRECT_MODE = 3'd5;
	localparam logic [2:0] REG_NUM_COLORS  = 3'd6;
	localparam logic [2:0] REG_DEFAULT_IDX = 3'd7;

	localparam int QUOT_W = 8;
	localparam int NUM_W  = 23;
	localparam int DEN_W  = 16;

	typedef struct packed {
		logic signed [17:0] lo_bound;
		logic signed [17:0] hi_bound;
		logic [DEN_W-1:0]   divisor;
		logic [7:0]         colors_m1;
		logic signed [15:0] thr_lower;
		logic signed [15:0] thr_upper;
		logic               thr_en;
		logic               direct;
		logic [7:0]         default_idx;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  entry_index;
		logic [31:0] color_word;
		logic        thr;
		logic        use_quot;
		logic [7:0]  base_idx;
	} side_t;

endpackage
`default_nettype wire

// ===== rtl/window_level_color_mapper.sv =====
// Window/level color mapper: maps signed samples to a color index and RGBA bytes.
// Top level; uses wlcm_pkg, wlcm_regs, wlcm_div and wlcm_cmem.
//
// Items enter on in_valid/in_stall and results leave on out_valid/out_stall; a
// transaction completes at a rising edge where valid is high and stall is low.
// Each accepted item yields exactly one result transaction, in order.
// Opcode 0 maps a sample, 1 writes a direct index entry, 2 writes a color word.
// Configuration registers are written over cfg_valid/cfg_ready with cfg_index
// and cfg_data; the user must write only with no item in flight (not enforced).
// From acceptance to out_valid an item passes three front stages, an eight-stage
// divider that produces one quotient bit per stage, and the color memory read
// that forms the output register.
// Throughput is one item per cycle while neither the receiver nor a clear stalls.
// A stall on out_stall while out_valid is high freezes the whole pipeline;
// in_stall rises in the same cycle, and nothing is lost or repeated.
// After reset the block clears both memories, one entry per cycle, holding
// in_stall high until every entry of the larger memory is clear.
`default_nettype none
module window_level_color_mapper #(
	parameter int COLOR_ENTRIES = wlcm_pkg::COLOR_ENTRIES_DEF,
	parameter int MAP_ENTRIES   = wlcm_pkg::MAP_ENTRIES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  opcode,
	input  wire logic signed [15:0] sample,
	input  wire logic [7:0]  entry_index,
	input  wire logic [31:0] color_word,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       color_index,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic [7:0]       alpha,
	output logic             thresholded,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int MAW     = $clog2(MAP_ENTRIES);
	localparam int CAW     = $clog2(COLOR_ENTRIES);
	localparam int CLR_LEN = (MAP_ENTRIES > COLOR_ENTRIES) ? MAP_ENTRIES : COLOR_ENTRIES;
	localparam int CLW     = $clog2(CLR_LEN + 1);
	localparam int SIDE_W  = $bits(wlcm_pkg::side_t);

	wlcm_pkg::cfg_t cfg;

	logic           adv;
	logic           accept;
	logic           clearing_q;
	logic [CLW-1:0] clr_cnt_q;
	logic           dclr;
	logic           cclr;

	logic [MAW-1:0] hi_mod [256];
	logic [15:0]    uaddr;
	logic [MAW:0]   asum;
	logic [MAW-1:0] map_addr;
	logic [8:0]     dmem [MAP_ENTRIES];

	logic               v_s1;
	logic [1:0]         op_s1;
	logic signed [15:0] sample_s1;
	logic [7:0]         entry_s1;
	logic [31:0]        word_s1;
	logic [8:0]         drd_s1;

	logic signed [17:0] ss;
	logic               le_lo;
	logic               ge_hi;
	logic               cut;
	logic [17:0]        diff_full;
	wlcm_pkg::side_t    side_c;

	logic               v_s2;
	wlcm_pkg::side_t    side_s2;
	logic [14:0]        diff_s2;

	logic               v_s3;
	wlcm_pkg::side_t    side_s3;
	logic [wlcm_pkg::NUM_W-1:0] prod_s3;

	logic               v_div;
	logic [7:0]         quot;
	logic [SIDE_W-1:0]  side_div_bits;
	wlcm_pkg::side_t    side_div;
	logic [7:0]         fidx;

	logic               out_valid_q;
	logic [7:0]         idx_q;
	logic               thr_q;
	logic [31:0]        rgba;

	wlcm_regs #(.COLOR_ENTRIES(COLOR_ENTRIES)) u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = clearing_q || !adv;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + CLW'(1);
			if (clr_cnt_q == CLW'(CLR_LEN - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	assign dclr = clearing_q && (clr_cnt_q < CLW'(MAP_ENTRIES));
	assign cclr = clearing_q && (clr_cnt_q < CLW'(COLOR_ENTRIES));

	for (genvar g = 0; g < 256; g++) begin : g_hi_mod
		assign hi_mod[g] = MAW'((g * 256) % MAP_ENTRIES);
	end

	always_comb begin
		uaddr = sample ^ 16'h8000;
		asum  = {1'b0, hi_mod[uaddr[15:8]]} + (MAW+1)'(uaddr[7:0]);
		if (asum >= (MAW+1)'(MAP_ENTRIES)) begin
			map_addr = MAW'(asum - (MAW+1)'(MAP_ENTRIES));
		end else begin
			map_addr = MAW'(asum);
		end
	end

	always_ff @(posedge clk) begin
		if (dclr) begin
			dmem[clr_cnt_q[MAW-1:0]] <= '0;
		end else if (accept && opcode == wlcm_pkg::OP_WR_DIRECT) begin
			dmem[map_addr] <= {1'b1, entry_index};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			drd_s1 <= dmem[map_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= accept;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_div;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1     <= opcode;
			sample_s1 <= sample;
			entry_s1  <= entry_index;
			word_s1   <= color_word;
		end
	end

	always_comb begin
		ss        = {{2{sample_s1[15]}}, sample_s1};
		le_lo     = ss <= cfg.lo_bound;
		ge_hi     = ss >= cfg.hi_bound;
		diff_full = ss - cfg.lo_bound;
		if (cfg.thr_lower <= cfg.thr_upper) begin
			cut = (sample_s1 < cfg.thr_lower) || (sample_s1 > cfg.thr_upper);
		end else begin
			cut = (sample_s1 >= cfg.thr_upper) && (sample_s1 <= cfg.thr_lower);
		end
		side_c.opcode      = op_s1;
		side_c.entry_index = entry_s1;
		side_c.color_word  = word_s1;
		side_c.thr         = (op_s1 == wlcm_pkg::OP_MAP) && cfg.thr_en && cut;
		side_c.use_quot    = !cfg.direct && !le_lo && !ge_hi;
		if (cfg.direct) begin
			side_c.base_idx = drd_s1[8] ? drd_s1[7:0] : cfg.default_idx;
		end else if (le_lo) begin
			side_c.base_idx = 8'd1;
		end else begin
			side_c.base_idx = cfg.colors_m1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2 <= side_c;
			diff_s2 <= diff_full[14:0];
			side_s3 <= side_s2;
			prod_s3 <= wlcm_pkg::NUM_W'(cfg.colors_m1) * wlcm_pkg::NUM_W'(diff_s2);
		end
	end

	wlcm_div #(.SIDE_W(SIDE_W)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s3),
		.num       (prod_s3),
		.den       (cfg.divisor),
		.side_in   (side_s3),
		.out_valid (v_div),
		.quot      (quot),
		.side_out  (side_div_bits)
	);

	assign side_div = wlcm_pkg::side_t'(side_div_bits);

	always_comb begin
		if (side_div.opcode != wlcm_pkg::OP_MAP || side_div.thr) begin
			fidx = 8'd0;
		end else if (side_div.use_quot) begin
			fidx = 8'(9'(quot) + 9'd1);
		end else begin
			fidx = side_div.base_idx;
		end
	end

	wlcm_cmem #(.COLOR_ENTRIES(COLOR_ENTRIES)) u_cmem (
		.clk      (clk),
		.en       (adv),
		.rd_idx   (fidx),
		.wr       (v_div && side_div.opcode == wlcm_pkg::OP_WR_COLOR),
		.wr_idx   (side_div.entry_index),
		.wr_data  (side_div.color_word),
		.clr      (cclr),
		.clr_addr (clr_cnt_q[CAW-1:0]),
		.rd_data  (rgba)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_q <= fidx;
			thr_q <= side_div.thr;
		end
	end

	assign out_valid   = out_valid_q;
	assign color_index = idx_q;
	assign thresholded = thr_q;
	assign red         = (idx_q == 8'd0) ? 8'd0 : rgba[7:0];
	assign green       = (idx_q == 8'd0) ? 8'd0 : rgba[15:8];
	assign blue        = (idx_q == 8'd0) ? 8'd0 : rgba[23:16];
	assign alpha       = (idx_q == 8'd0) ? 8'd0 : rgba[31:24];

	a_thr_transparent: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && thresholded) |-> (color_index == 8'd0))
		else $error("thresholded result with nonzero index");

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> (!out_valid && !v_s1 && !v_s2 && !v_s3 && !v_div))
		else $error("pipeline not empty during memory clear");

	a_alpha_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && alpha != 8'd0) |-> (color_index != 8'd0))
		else $error("nonzero alpha on transparent index");

endmodule
`default_nettype wire

// ===== rtl/wlcm_regs.sv =====
// Configuration registers and the window bounds derived from them.
// Depends on wlcm_pkg.
`default_nettype none
module wlcm_regs #(
	parameter int COLOR_ENTRIES = wlcm_pkg::COLOR_ENTRIES_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [15:0]   cfg_data,
	output wlcm_pkg::cfg_t     cfg
);

	localparam int TOP_COLORS = (COLOR_ENTRIES < 256) ? COLOR_ENTRIES : 256;

	logic [14:0]        window_q;
	logic signed [15:0] level_q;
	logic signed [15:0] thr_lower_q;
	logic signed [15:0] thr_upper_q;
	logic               thr_en_q;
	logic               direct_q;
	logic [8:0]         ncol_q;
	logic [7:0]         default_idx_q;

	logic               wr;
	logic signed [17:0] lo;
	logic [8:0]         ncol;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q      <= 15'd256;
			level_q       <= 16'sd128;
			thr_lower_q   <= 16'sh8000;
			thr_upper_q   <= 16'sh7FFF;
			thr_en_q      <= 1'b1;
			direct_q      <= 1'b0;
			ncol_q        <= 9'd256;
			default_idx_q <= 8'd1;
		end else if (wr) begin
			unique case (cfg_index)
				wlcm_pkg::REG_WINDOW:      window_q      <= cfg_data[14:0];
				wlcm_pkg::REG_LEVEL:       level_q       <= cfg_data;
				wlcm_pkg::REG_THR_LOWER:   thr_lower_q   <= cfg_data;
				wlcm_pkg::REG_THR_UPPER:   thr_upper_q   <= cfg_data;
				wlcm_pkg::REG_THR_ENABLE:  thr_en_q      <= cfg_data[0];
				wlcm_pkg::REG_DIRECT_MODE: direct_q      <= cfg_data[0];
				wlcm_pkg::REG_NUM_COLORS:  ncol_q        <= cfg_data[8:0];
				wlcm_pkg::REG_DEFAULT_IDX: default_idx_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		lo = 18'({{2{level_q[15]}}, level_q}) - 18'({3'b000, window_q[14:1]});
		if (ncol_q < 9'd2) begin
			ncol = 9'd2;
		end else if (ncol_q > 9'(TOP_COLORS)) begin
			ncol = 9'(TOP_COLORS);
		end else begin
			ncol = ncol_q;
		end
		cfg.lo_bound = lo;
		if (window_q < 15'd2) begin
			cfg.hi_bound = lo + 18'sd1;
			cfg.divisor  = wlcm_pkg::DEN_W'(2);
		end else begin
			cfg.hi_bound = lo + 18'({3'b000, window_q}) - 18'sd1;
			cfg.divisor  = wlcm_pkg::DEN_W'(window_q);
		end
		cfg.colors_m1   = 8'(ncol - 9'd1);
		cfg.thr_lower   = thr_lower_q;
		cfg.thr_upper   = thr_upper_q;
		cfg.thr_en      = thr_en_q;
		cfg.direct      = direct_q;
		cfg.default_idx = default_idx_q;
	end

endmodule
`default_nettype wire

// ===== rtl/wlcm_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sideband data.
// Depends on wlcm_pkg.
`default_nettype none
module wlcm_div #(
	parameter int SIDE_W = 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        in_valid,
	input  wire logic [wlcm_pkg::NUM_W-1:0]  num,
	input  wire logic [wlcm_pkg::DEN_W-1:0]  den,
	input  wire logic [SIDE_W-1:0]           side_in,
	output logic                             out_valid,
	output logic [wlcm_pkg::QUOT_W-1:0]      quot,
	output logic [SIDE_W-1:0]                side_out
);

	localparam int QW = wlcm_pkg::QUOT_W;
	localparam int NW = wlcm_pkg::NUM_W;

	logic          vld_s  [QW];
	logic [NW-1:0] rem_s  [QW];
	logic [QW-1:0] quo_s  [QW];
	logic [SIDE_W-1:0] side_s [QW];

	for (genvar j = 0; j < QW; j++) begin : g_stage
		localparam int B = QW - 1 - j;
		logic              v_in;
		logic [NW-1:0]     r_in;
		logic [QW-1:0]     q_in;
		logic [SIDE_W-1:0] sd_in;
		logic [NW-1:0]     trial;
		logic              take;

		if (j == 0) begin : g_first
			assign v_in  = in_valid;
			assign r_in  = num;
			assign q_in  = '0;
			assign sd_in = side_in;
		end else begin : g_next
			assign v_in  = vld_s[j-1];
			assign r_in  = rem_s[j-1];
			assign q_in  = quo_s[j-1];
			assign sd_in = side_s[j-1];
		end

		assign trial = NW'(den) << B;
		assign take  = r_in >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= take ? (r_in - trial) : r_in;
				quo_s[j]  <= q_in | (take ? (QW'(1) << B) : '0);
				side_s[j] <= sd_in;
			end
		end
	end

	assign out_valid = vld_s[QW-1];
	assign quot      = quo_s[QW-1];
	assign side_out  = side_s[QW-1];

endmodule
`default_nettype wire

// ===== rtl/wlcm_cmem.sv =====
// Color word memory with one registered read port and one write port.
// Depends on wlcm_pkg only for its default depth; used by the top level.
`default_nettype none
module wlcm_cmem #(
	parameter int COLOR_ENTRIES = wlcm_pkg::COLOR_ENTRIES_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             en,
	input  wire logic [7:0]                       rd_idx,
	input  wire logic                             wr,
	input  wire logic [7:0]                       wr_idx,
	input  wire logic [31:0]                      wr_data,
	input  wire logic                             clr,
	input  wire logic [$clog2(COLOR_ENTRIES)-1:0] clr_addr,
	output logic [31:0]                           rd_data
);

	localparam int CAW = $clog2(COLOR_ENTRIES);

	logic [31:0]    mem [COLOR_ENTRIES];
	logic [CAW-1:0] mod_tbl [256];

	for (genvar g = 0; g < 256; g++) begin : g_mod
		assign mod_tbl[g] = CAW'(g % COLOR_ENTRIES);
	end

	always_ff @(posedge clk) begin
		if (clr) begin
			mem[clr_addr] <= '0;
		end else if (en && wr) begin
			mem[mod_tbl[wr_idx]] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rd_data <= mem[mod_tbl[rd_idx]];
		end
	end

endmodule
`default_nettype wire

// ===== tb/sv/wlcm_checker.sv =====
// Checker for the window/level color mapper: watches the item, result and register channels,
// predicts each result and compares it field by field. Depends on wlcm_pkg.
`default_nettype none
module wlcm_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [1:0]  opcode,
	input  wire logic signed [15:0] sample,
	input  wire logic [7:0]  entry_index,
	input  wire logic [31:0] color_word,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [7:0]  color_index,
	input  wire logic [7:0]  red,
	input  wire logic [7:0]  green,
	input  wire logic [7:0]  blue,
	input  wire logic [7:0]  alpha,
	input  wire logic        thresholded,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	output int               fail_count,
	output int               pending
);

	typedef struct packed {
		logic [7:0]  idx;
		logic [31:0] rgba;
		logic        thr;
	} pixel_t;

	logic [14:0]        win_q;
	logic signed [15:0] lvl_q, thr_lo_q, thr_hi_q;
	logic               thr_en_q, direct_q;
	logic [8:0]         ncol_q;
	logic [7:0]         dflt_q;
	logic [8:0]         index_map [0:65535];
	logic [31:0]        palette [0:255];
	pixel_t             expected_pixels[$];

	function automatic logic [7:0] ramp_lookup(input logic signed [15:0] s);
		longint colors, lo, hi, w;
		colors = longint'(ncol_q);
		if (colors < 2) colors = 2;
		if (colors > 256) colors = 256;
		w = longint'(win_q);
		lo = longint'(lvl_q) - w / 2;
		hi = lo + w - 1;
		if (hi <= lo) hi = lo + 1;
		if (longint'(s) <= lo) return 8'd1;
		if (longint'(s) >= hi) return 8'(colors - 1);
		return 8'(1 + ((colors - 1) * (longint'(s) - lo)) / (hi - lo + 1));
	endfunction

	function automatic pixel_t map_pixel(input logic [1:0] op, input logic signed [15:0] s,
		input logic [7:0] ent);
		pixel_t p;
		logic [15:0] a;
		logic cut;
		p = '0;
		a = s + 16'h8000;
		if (op == wlcm_pkg::OP_MAP) begin
			if (direct_q) p.idx = index_map[a][8] ? index_map[a][7:0] : dflt_q;
			else p.idx = ramp_lookup(s);
			if (thr_en_q) begin
				if (thr_lo_q <= thr_hi_q) cut = (s < thr_lo_q) || (s > thr_hi_q);
				else cut = (s >= thr_hi_q) && (s <= thr_lo_q);
				if (cut) begin
					p.idx = '0;
					p.thr = 1'b1;
				end
			end
			if (p.idx != 8'd0) p.rgba = palette[p.idx];
		end
		return p;
	endfunction

	assign pending = expected_pixels.size();

	always @(posedge clk or negedge arst_n) begin
		pixel_t got, want;
		logic [15:0] a;
		if (!arst_n) begin
			win_q <= 15'd256;
			lvl_q <= 16'sd128;
			thr_lo_q <= 16'sh8000;
			thr_hi_q <= 16'sh7FFF;
			thr_en_q <= 1'b1;
			direct_q <= 1'b0;
			ncol_q <= 9'd256;
			dflt_q <= 8'd1;
			for (int i = 0; i < 65536; i++) index_map[i] = '0;
			for (int i = 0; i < 256; i++) palette[i] = '0;
			expected_pixels.delete();
			fail_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					wlcm_pkg::REG_WINDOW:      win_q <= cfg_data[14:0];
					wlcm_pkg::REG_LEVEL:       lvl_q <= cfg_data;
					wlcm_pkg::REG_THR_LOWER:   thr_lo_q <= cfg_data;
					wlcm_pkg::REG_THR_UPPER:   thr_hi_q <= cfg_data;
					wlcm_pkg::REG_THR_ENABLE:  thr_en_q <= cfg_data[0];
					wlcm_pkg::REG_DIRECT_MODE: direct_q <= cfg_data[0];
					wlcm_pkg::REG_NUM_COLORS:  ncol_q <= cfg_data[8:0];
					wlcm_pkg::REG_DEFAULT_IDX: dflt_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				got = '{color_index, {alpha, blue, green, red}, thresholded};
				if (expected_pixels.size() == 0) begin
					$error("unexpected result transaction, color_index %0d", color_index);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_pixels.pop_front();
					if (got != want) begin
						fail_count <= fail_count + 1;
						if (got.idx != want.idx)
							$error("color_index expected %0d got %0d", want.idx, got.idx);
						if (got.rgba[7:0] != want.rgba[7:0])
							$error("red expected %0d got %0d", want.rgba[7:0], got.rgba[7:0]);
						if (got.rgba[15:8] != want.rgba[15:8])
							$error("green expected %0d got %0d", want.rgba[15:8], got.rgba[15:8]);
						if (got.rgba[23:16] != want.rgba[23:16])
							$error("blue expected %0d got %0d", want.rgba[23:16], got.rgba[23:16]);
						if (got.rgba[31:24] != want.rgba[31:24])
							$error("alpha expected %0d got %0d", want.rgba[31:24], got.rgba[31:24]);
						if (got.thr != want.thr)
							$error("thresholded expected %0d got %0d", want.thr, got.thr);
					end
				end
			end
			if (in_valid && !in_stall) begin
				expected_pixels.push_back(map_pixel(opcode, sample, entry_index));
				a = sample + 16'h8000;
				if (opcode == wlcm_pkg::OP_WR_DIRECT) index_map[a] = {1'b1, entry_index};
				if (opcode == wlcm_pkg::OP_WR_COLOR) palette[entry_index] = color_word;
			end
		end
	end
endmodule
`default_nettype wire

// ===== tb/sv/tb_window_level_color_mapper.sv =====
// Testbench top for the window/level color mapper: drives items, register writes and stalls.
// Depends on wlcm_pkg, window_level_color_mapper and wlcm_checker.
`default_nettype none
module tb_window_level_color_mapper;

	logic        clk, arst_n;
	logic        in_valid, in_stall, out_valid, out_stall;
	logic [1:0]  opcode;
	logic signed [15:0] sample;
	logic [7:0]  entry_index, color_index, red, green, blue, alpha;
	logic [31:0] color_word;
	logic        thresholded, cfg_valid, cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	int          fail_count, pending, cycle_count;
	int          send_idle_pct, stall_pct, hold_off;

	window_level_color_mapper i_dut (.*);
	wlcm_checker i_checker (.*);

	function automatic bit direct_q_hint(input int phase);
		return phase % 2 == 1;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 600000) begin
				$display("window_level_color_mapper test failed");
				$finish;
			end
		end
	end

	initial begin
		out_stall = 0;
		forever begin
			@(posedge clk);
			if (hold_off > 0) begin
				out_stall <= 1;
				repeat (hold_off) @(posedge clk);
				hold_off = 0;
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
	endtask

	task automatic send_item(input logic [1:0] op, input logic [15:0] s, input logic [7:0] ent,
		input logic [31:0] word);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		opcode <= op;
		sample <= s;
		entry_index <= ent;
		color_word <= word;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain;
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic random_item;
		int r;
		r = $urandom_range(99);
		if (r < 70)
			send_item(wlcm_pkg::OP_MAP, 16'($urandom), 8'($urandom), $urandom);
		else if (r < 82)
			send_item(wlcm_pkg::OP_WR_DIRECT, 16'($urandom), 8'($urandom), $urandom);
		else if (r < 96)
			send_item(wlcm_pkg::OP_WR_COLOR, 16'($urandom), 8'($urandom), $urandom);
		else
			send_item(wlcm_pkg::OP_UNUSED, 16'($urandom), 8'($urandom), $urandom);
	endtask

	task automatic random_config(input int phase);
		logic [15:0] a, b;
		case (phase % 4)
			0: write_reg(wlcm_pkg::REG_WINDOW, 16'd1);
			1: write_reg(wlcm_pkg::REG_WINDOW, 16'h7FFF);
			2: write_reg(wlcm_pkg::REG_WINDOW, 16'd0);
			default: write_reg(wlcm_pkg::REG_WINDOW, 16'($urandom_range(1, 2000)));
		endcase
		write_reg(wlcm_pkg::REG_LEVEL, (phase % 3 == 0) ? 16'h8000 :
			(phase % 3 == 1) ? 16'h7FFF : 16'($urandom_range(0, 2000) - 1000));
		a = 16'($urandom);
		b = 16'($urandom);
		write_reg(wlcm_pkg::REG_THR_LOWER, a);
		write_reg(wlcm_pkg::REG_THR_UPPER, b);
		write_reg(wlcm_pkg::REG_THR_ENABLE, 16'($urandom_range(1)));
		write_reg(wlcm_pkg::REG_DIRECT_MODE, 16'(phase % 2));
		write_reg(wlcm_pkg::REG_NUM_COLORS, 16'((phase % 5 == 0) ? 9'd0 :
			(phase % 5 == 1) ? 9'd511 : (phase % 5 == 2) ? 9'd2 :
			9'($urandom_range(2, 256))));
		write_reg(wlcm_pkg::REG_DEFAULT_IDX, 16'($urandom));
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		opcode = wlcm_pkg::OP_MAP;
		sample = 0;
		entry_index = 0;
		color_word = 0;
		cfg_valid = 0;
		cfg_index = wlcm_pkg::REG_WINDOW;
		cfg_data = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_off = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_item(wlcm_pkg::OP_MAP, 16'h8000, 8'd0, 32'd0);
		send_item(wlcm_pkg::OP_MAP, 16'h7FFF, 8'd0, 32'd0);
		for (int i = 0; i < 8; i++)
			send_item(wlcm_pkg::OP_WR_COLOR, 16'd0, 8'd1 << i, 32'h1 << (i * 4));
		send_item(wlcm_pkg::OP_WR_COLOR, 16'd0, 8'hFF, 32'hFFFFFFFF);
		send_item(wlcm_pkg::OP_WR_COLOR, 16'd0, 8'h00, 32'hA5A5A5A5);
		send_item(wlcm_pkg::OP_MAP, 16'sd0, 8'd0, 32'd0);
		send_item(wlcm_pkg::OP_MAP, 16'sd300, 8'd0, 32'd0);
		send_item(wlcm_pkg::OP_MAP, 16'sd100, 8'd0, 32'd0);
		send_item(wlcm_pkg::OP_WR_DIRECT, 16'h8000, 8'hFF, 32'd0);
		send_item(wlcm_pkg::OP_WR_DIRECT, 16'h7FFF, 8'h00, 32'd0);
		send_item(wlcm_pkg::OP_UNUSED, 16'h1234, 8'h55, 32'hFFFFFFFF);
		drain();
		write_reg(wlcm_pkg::REG_DIRECT_MODE, 16'd1);
		write_reg(wlcm_pkg::REG_THR_LOWER, 16'sd10);
		write_reg(wlcm_pkg::REG_THR_UPPER, -16'sd10);
		send_item(wlcm_pkg::OP_MAP, 16'h8000, 8'd0, 32'd0);
		send_item(wlcm_pkg::OP_MAP, 16'h7FFF, 8'd0, 32'd0);
		send_item(wlcm_pkg::OP_MAP, 16'sd0, 8'd0, 32'd0);
		send_item(wlcm_pkg::OP_MAP, 16'sd55, 8'd0, 32'd0);
		drain();

		for (int phase = 0; phase < 14; phase++) begin
			random_config(phase);
			case (phase % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 62; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 62; end
				default: begin send_idle_pct = 33; stall_pct = 33; end
			endcase
			if (phase == 4) hold_off = 120;
			for (int i = 0; i < 75; i++) begin
				if (direct_q_hint(phase) && $urandom_range(3) == 0)
					send_item(wlcm_pkg::OP_WR_DIRECT, 16'($urandom_range(0, 63)),
						8'($urandom), 32'd0);
				else if ($urandom_range(3) == 0)
					send_item(wlcm_pkg::OP_MAP, 16'($urandom_range(0, 63)), 8'd0, $urandom);
				else
					random_item();
			end
			drain();
		end

		if (fail_count == 0)
			$display("window_level_color_mapper test passed");
		else
			$display("window_level_color_mapper test failed");
		$finish;
	end
endmodule
`default_nettype wire

// ===== window_level_color_mapper.f =====
rtl/wlcm_pkg.sv
rtl/wlcm_regs.sv
rtl/wlcm_div.sv
rtl/wlcm_cmem.sv
rtl/window_level_color_mapper.sv
tb/sv/wlcm_checker.sv
tb/sv/tb_window_level_color_mapper.sv
